[src/json_stream_tokenizer_core_defines.svh]
// Assertion macros for the tokenizer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef JSON_STREAM_TOKENIZER_CORE_DEFINES_SVH
`define JSON_STREAM_TOKENIZER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JST_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define JST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

[src/jst_pkg.sv]
// Package for the JSON stream tokenizer: codes, limits and the character class type.
// No dependencies; used by jst_char_class, the top level and the testbench.
package jst_pkg;

    localparam int DEF_MAX_TOKENS = 64;
    localparam int DEF_MAX_TEXT   = 65536;

    localparam logic [6:0] TOKEN_LIMIT_RST = 7'd64;
    localparam logic [6:0] CNT_MAX         = 7'd127;
    localparam logic [16:0] POS_NONE       = 17'h1FFFF;

    localparam logic [1:0] CMD_FEED    = 2'd0;
    localparam logic [1:0] CMD_FINISH  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_NOMEM = 2'd2;
    localparam logic [1:0] ST_PART  = 2'd3;

    localparam logic [2:0] M_ROOT         = 3'd0;
    localparam logic [2:0] M_STRING       = 3'd1;
    localparam logic [2:0] M_PRIM         = 3'd2;
    localparam logic [2:0] M_AFTER_STRING = 3'd3;
    localparam logic [2:0] M_AFTER_PRIM   = 3'd4;

    localparam logic [1:0] T_PRIM   = 2'd0;
    localparam logic [1:0] T_OBJECT = 2'd1;
    localparam logic [1:0] T_ARRAY  = 2'd2;
    localparam logic [1:0] T_STRING = 2'd3;

    typedef struct packed {
        logic obj_open;
        logic arr_open;
        logic obj_close;
        logic arr_close;
        logic quote;
        logic space;
        logic colon;
        logic comma;
        logic backslash;
        logic esc_ok;
        logic printable;
    } t_char_class;

endpackage

[src/jst_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module jst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/jst_char_class.sv]
// Character classifier for the tokenizer: sorts one text byte into JSON classes.
// Depends on jst_pkg.
module jst_char_class (
    input  logic [7:0]           i_char,
    output jst_pkg::t_char_class o_class
);
    import jst_pkg::*;

    always_comb begin
        o_class.obj_open  = (i_char == 8'h7B);
        o_class.arr_open  = (i_char == 8'h5B);
        o_class.obj_close = (i_char == 8'h7D);
        o_class.arr_close = (i_char == 8'h5D);
        o_class.quote     = (i_char == 8'h22);
        o_class.space     = (i_char == 8'h09) || (i_char == 8'h0D) ||
                            (i_char == 8'h0A) || (i_char == 8'h20);
        o_class.colon     = (i_char == 8'h3A);
        o_class.comma     = (i_char == 8'h2C);
        o_class.backslash = (i_char == 8'h5C);
        // Bytes allowed after a backslash.
        o_class.esc_ok    = (i_char == 8'h22) || (i_char == 8'h2F) || (i_char == 8'h5C) ||
                            (i_char == 8'h62) || (i_char == 8'h66) || (i_char == 8'h72) ||
                            (i_char == 8'h6E) || (i_char == 8'h74);
        o_class.printable = (i_char >= 8'd32) && (i_char < 8'd127);
    end
endmodule

[src/json_stream_tokenizer_core.sv]
// Top level of the JSON stream tokenizer: command sequencer around the token table RAM.
// Depends on jst_pkg, jst_ram, jst_char_class and json_stream_tokenizer_core_defines.svh.
//
//  Channel   Signals                                        Transfer
//  --------  ---------------------------------------------  -------------------------------
//  command   start, busy, i_command, i_char_code,           start high while busy is low
//            i_token_index
//  result    o_done, o_status, o_parse_mode,                one cycle with o_done high
//            o_tokens_found, o_entry_*
//  config    i_cfg_we, i_cfg_wdata                          any edge with i_cfg_we high
//
// Each command is worked off one at a time by a sequencer that owns the single read port and
// the single write port of the token table. A byte inside a string, a restart or a finish on
// an empty table passes only the dispatch and done states; any other byte at root level also
// passes the root state, and an entry read the readout state. Ending a string, opening a
// bracket or ending a primitive adds the parent update state when the parent's child count is
// updated. A closing bracket, a comma after a keyed value and the finish check walk back
// through the table in the search state, visiting one entry after another.
// Reset is synchronous and active low; the token table is not cleared and needs no sweep.
// The result cannot be stalled; busy stays high until the cycle after o_done.
module json_stream_tokenizer_core #(
    parameter int MAX_TOKENS = jst_pkg::DEF_MAX_TOKENS,
    parameter int MAX_TEXT   = jst_pkg::DEF_MAX_TEXT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_char_code,
    input  logic [5:0]  i_token_index,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [2:0]  o_parse_mode,
    output logic [6:0]  o_tokens_found,
    output logic [1:0]  o_entry_type,
    output logic [16:0] o_entry_start,
    output logic [16:0] o_entry_end,
    output logic [6:0]  o_entry_children
);
    import jst_pkg::*;

    `include "json_stream_tokenizer_core_defines.svh"

    // Table address, allocation count and text position widths.
    localparam int AW = $clog2(MAX_TOKENS);
    localparam int NW = $clog2(MAX_TOKENS + 1);
    localparam int PW = $clog2(MAX_TEXT);
    localparam int LW = (NW > 7) ? NW : 7;

    // Entry layout: type, start valid, start, end valid, end, children.
    localparam int CH_LO = 0;
    localparam int EN_LO = 7;
    localparam int EV_B  = 7 + PW;
    localparam int SP_LO = 8 + PW;
    localparam int SV_B  = 8 + 2 * PW;
    localparam int TY_LO = 9 + 2 * PW;
    localparam int EW    = 11 + 2 * PW;

    localparam logic [PW:0]   TEXT_TOP  = (PW + 1)'(MAX_TEXT);
    localparam logic [PW-1:0] TEXT_LAST = PW'(MAX_TEXT - 1);
    localparam logic [LW-1:0] TOK_MAX   = LW'(MAX_TOKENS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_ROOT  = 3'd2;
    localparam logic [2:0] S_PINC  = 3'd3;
    localparam logic [2:0] S_COMMA = 3'd4;
    localparam logic [2:0] S_SRCH  = 3'd5;
    localparam logic [2:0] S_RDOUT = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // Kinds of backward walk.
    localparam logic [1:0] K_FINISH = 2'd0;
    localparam logic [1:0] K_CLOSE  = 2'd1;
    localparam logic [1:0] K_PARENT = 2'd2;
    localparam logic [1:0] K_COMMA  = 2'd3;

    function automatic logic [PW-1:0] f_pos_inc(input logic [PW-1:0] p);
        logic [PW:0] s;
        s = {1'b0, p} + 1'b1;
        return (s >= TEXT_TOP) ? '0 : s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] f_pos_dec(input logic [PW-1:0] p);
        return (p == '0) ? TEXT_LAST : p - 1'b1;
    endfunction

    function automatic logic [6:0] f_sat_inc(input logic [6:0] x);
        return (x == CNT_MAX) ? x : x + 1'b1;
    endfunction

    function automatic logic [16:0] f_pos_out(input logic valid, input logic [PW-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return valid ? w[16:0] : POS_NONE;
    endfunction

    function automatic logic [EW-1:0] f_pack(input logic [1:0] ty, input logic sv,
                                             input logic [PW-1:0] sp, input logic ev,
                                             input logic [PW-1:0] ep, input logic [6:0] ch);
        return {ty, sv, sp, ev, ep, ch};
    endfunction

    // Registers.
    logic [2:0]    r_state, n_state;
    logic [1:0]    r_cmd, n_cmd;
    logic [7:0]    r_char, n_char;
    logic [5:0]    r_index, n_index;
    logic [6:0]    r_tlim, n_tlim;
    logic [PW-1:0] r_tp, n_tp;
    logic [PW-1:0] r_istart, n_istart;
    logic [NW-1:0] r_nfe, n_nfe;
    logic          r_op_v, n_op_v;
    logic [AW-1:0] r_op, n_op;
    logic [6:0]    r_tt, n_tt;
    logic [2:0]    r_mode, n_mode;
    logic          r_esc, n_esc;
    logic [1:0]    r_status, n_status;
    logic          r_reparse, n_reparse;
    logic          r_feed, n_feed;
    logic          r_to_root, n_to_root;
    logic [1:0]    r_kind, n_kind;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_paddr, n_paddr;
    logic [1:0]    r_ety, n_ety;
    logic [16:0]   r_est, n_est;
    logic [16:0]   r_een, n_een;
    logic [6:0]    r_ech, n_ech;

    // Table port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    t_char_class   cls;
    logic          accept;
    logic          delim;
    logic          table_full;
    logic [LW-1:0] lim;
    logic [NW-1:0] nfe_m1;
    logic [31:0]   idx_ext;
    logic          rd_open;
    logic [1:0]    rd_type;
    logic [1:0]    close_type;

    jst_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TOKENS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    jst_char_class u_class (
        .i_char  (r_char),
        .o_class (cls)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // A primitive ends on whitespace, a colon, a comma or a closing bracket.
    assign delim = cls.colon || cls.space || cls.comma || cls.arr_close || cls.obj_close;

    // The usable table size is the smaller of the register and the table depth.
    assign lim        = (LW'(r_tlim) < TOK_MAX) ? LW'(r_tlim) : TOK_MAX;
    assign table_full = (LW'(r_nfe) >= lim);
    assign nfe_m1     = r_nfe - 1'b1;
    assign idx_ext    = 32'(r_index);

    assign rd_type    = ram_rdata[TY_LO +: 2];
    assign rd_open    = ram_rdata[SV_B] && !ram_rdata[EV_B];
    assign close_type = cls.obj_close ? T_OBJECT : T_ARRAY;

    // The sequencer never uses a read of an entry issued in the same cycle as it writes it: every
    // read-modify-write issues the read, takes the data in the next cycle and writes then,
    // and the next command cannot start before that write has landed.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_char    = r_char;
        n_index   = r_index;
        n_tlim    = i_cfg_we ? i_cfg_wdata : r_tlim;
        n_tp      = r_tp;
        n_istart  = r_istart;
        n_nfe     = r_nfe;
        n_op_v    = r_op_v;
        n_op      = r_op;
        n_tt      = r_tt;
        n_mode    = r_mode;
        n_esc     = r_esc;
        n_status  = r_status;
        n_reparse = r_reparse;
        n_feed    = r_feed;
        n_to_root = r_to_root;
        n_kind    = r_kind;
        n_ptr     = r_ptr;
        n_paddr   = r_paddr;
        n_ety     = r_ety;
        n_est     = r_est;
        n_een     = r_een;
        n_ech     = r_ech;
        ram_we    = 1'b0;
        ram_waddr = r_nfe[AW-1:0];
        ram_wdata = '0;
        ram_raddr = r_op;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd   = i_command;
                    n_char  = i_char_code;
                    n_index = i_token_index;
                    n_state = S_DISP;
                end
            end

            S_DISP: begin
                n_status  = ST_OK;
                n_reparse = 1'b0;
                n_feed    = 1'b0;
                n_ety     = '0;
                n_est     = '0;
                n_een     = '0;
                n_ech     = '0;
                n_state   = S_DONE;
                case (r_cmd)
                    CMD_READ: begin
                        if (idx_ext < 32'(MAX_TOKENS)) begin
                            ram_raddr = idx_ext[AW-1:0];
                            n_state   = S_RDOUT;
                        end
                    end
                    CMD_RESTART: begin
                        n_tp     = '0;
                        n_nfe    = '0;
                        n_op_v   = 1'b0;
                        n_tt     = '0;
                        n_mode   = M_ROOT;
                        n_istart = '0;
                        n_esc    = 1'b0;
                    end
                    CMD_FINISH: begin
                        if (r_nfe != '0) begin
                            ram_raddr = nfe_m1[AW-1:0];
                            n_ptr     = nfe_m1[AW-1:0];
                            n_kind    = K_FINISH;
                            n_state   = S_SRCH;
                        end
                    end
                    default: begin
                        n_feed = 1'b1;
                        if (r_mode == M_STRING) begin
                            if (r_esc) begin
                                n_esc = 1'b0;
                                if (!cls.esc_ok) begin
                                    n_tp     = r_istart;
                                    n_status = ST_INVAL;
                                end
                            end else if (cls.backslash) begin
                                n_esc = 1'b1;
                            end else if (cls.quote) begin
                                if (table_full) begin
                                    n_tp     = r_istart;
                                    n_status = ST_NOMEM;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_wdata = f_pack(T_STRING, 1'b1, f_pos_inc(r_istart),
                                                       1'b1, r_tp, '0);
                                    n_nfe     = r_nfe + 1'b1;
                                    n_tt      = f_sat_inc(r_tt);
                                    n_mode    = M_AFTER_STRING;
                                    if (r_op_v) begin
                                        n_paddr   = r_op;
                                        n_to_root = 1'b0;
                                        n_state   = S_PINC;
                                    end
                                end
                            end
                        end else if (r_mode == M_PRIM) begin
                            if (delim) begin
                                if (table_full) begin
                                    n_tp     = r_istart;
                                    n_status = ST_NOMEM;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_wdata = f_pack(T_PRIM, 1'b1, r_istart, 1'b1, r_tp, '0);
                                    n_nfe     = r_nfe + 1'b1;
                                    n_tt      = f_sat_inc(r_tt);
                                    n_mode    = M_AFTER_PRIM;
                                    // The delimiter is then parsed again at root level.
                                    n_reparse = 1'b1;
                                    if (r_op_v) begin
                                        n_paddr   = r_op;
                                        n_to_root = 1'b1;
                                        n_state   = S_PINC;
                                    end else begin
                                        n_state = S_ROOT;
                                    end
                                end
                            end else if (!cls.printable) begin
                                n_tp     = r_istart;
                                n_status = ST_INVAL;
                            end
                        end else begin
                            n_state = S_ROOT;
                        end
                    end
                endcase
            end

            S_ROOT: begin
                n_mode  = M_ROOT;
                n_state = S_DONE;
                if (cls.obj_open || cls.arr_open) begin
                    // The token count grows even when no entry is free.
                    n_tt = f_sat_inc(r_tt);
                    if (table_full) begin
                        n_status = ST_NOMEM;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = f_pack(cls.obj_open ? T_OBJECT : T_ARRAY, 1'b1, r_tp,
                                           1'b0, '0, '0);
                        n_nfe     = r_nfe + 1'b1;
                        n_op_v    = 1'b1;
                        n_op      = r_nfe[AW-1:0];
                        if (r_op_v) begin
                            n_paddr   = r_op;
                            n_to_root = 1'b0;
                            n_state   = S_PINC;
                        end
                    end
                end else if (cls.obj_close || cls.arr_close) begin
                    if (r_nfe == '0) begin
                        n_status = ST_INVAL;
                    end else begin
                        ram_raddr = nfe_m1[AW-1:0];
                        n_ptr     = nfe_m1[AW-1:0];
                        n_kind    = K_CLOSE;
                        n_state   = S_SRCH;
                    end
                end else if (cls.quote) begin
                    n_istart = r_tp;
                    n_esc    = 1'b0;
                    n_mode   = M_STRING;
                end else if (cls.colon) begin
                    n_op_v = (r_nfe != '0);
                    n_op   = nfe_m1[AW-1:0];
                end else if (cls.comma) begin
                    // After a keyed value the parent goes back to the enclosing container.
                    if (r_op_v) begin
                        ram_raddr = r_op;
                        n_state   = S_COMMA;
                    end
                end else if (!cls.space) begin
                    n_istart = r_tp;
                    n_mode   = M_PRIM;
                end
            end

            S_PINC: begin
                ram_we    = 1'b1;
                ram_waddr = r_paddr;
                ram_wdata = {ram_rdata[EW-1:7], f_sat_inc(ram_rdata[CH_LO +: 7])};
                n_state   = r_to_root ? S_ROOT : S_DONE;
            end

            S_COMMA: begin
                n_state = S_DONE;
                if ((rd_type == T_PRIM || rd_type == T_STRING) && r_nfe != '0) begin
                    ram_raddr = nfe_m1[AW-1:0];
                    n_ptr     = nfe_m1[AW-1:0];
                    n_kind    = K_COMMA;
                    n_state   = S_SRCH;
                end
            end

            S_SRCH: begin
                // Data of entry r_ptr is on the read port; the next lower entry is
                // requested in the same cycle, even when the walk ends here.
                ram_raddr = r_ptr - 1'b1;
                n_ptr     = r_ptr - 1'b1;
                case (r_kind)
                    K_FINISH: begin
                        if (rd_open) begin
                            n_status = ST_PART;
                            n_state  = S_DONE;
                        end else if (r_ptr == '0) begin
                            n_state = S_DONE;
                        end
                    end
                    K_CLOSE: begin
                        if (rd_open) begin
                            if (rd_type != close_type) begin
                                n_status = ST_INVAL;
                                n_state  = S_DONE;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_ptr;
                                ram_wdata = f_pack(rd_type, 1'b1, ram_rdata[SP_LO +: PW],
                                                   1'b1, f_pos_inc(r_tp),
                                                   ram_rdata[CH_LO +: 7]);
                                n_op_v    = 1'b0;
                                n_kind    = K_PARENT;
                                if (r_ptr == '0) begin
                                    n_state = S_DONE;
                                end
                            end
                        end else if (r_ptr == '0) begin
                            n_status = ST_INVAL;
                            n_state  = S_DONE;
                        end
                    end
                    K_PARENT: begin
                        if (rd_open) begin
                            n_op_v  = 1'b1;
                            n_op    = r_ptr;
                            n_state = S_DONE;
                        end else if (r_ptr == '0) begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        if (rd_open && (rd_type == T_ARRAY || rd_type == T_OBJECT)) begin
                            n_op_v  = 1'b1;
                            n_op    = r_ptr;
                            n_state = S_DONE;
                        end else if (r_ptr == '0) begin
                            n_state = S_DONE;
                        end
                    end
                endcase
            end

            S_RDOUT: begin
                n_ety   = rd_type;
                n_est   = f_pos_out(ram_rdata[SV_B], ram_rdata[SP_LO +: PW]);
                n_een   = f_pos_out(ram_rdata[EV_B], ram_rdata[EN_LO +: PW]);
                n_ech   = ram_rdata[CH_LO +: 7];
                n_state = S_DONE;
            end

            S_DONE: begin
                // The text position moves once the character is fully handled; a failed
                // reparsed delimiter steps back over the primitive's end instead.
                if (r_feed) begin
                    if (r_status == ST_OK) begin
                        n_tp = f_pos_inc(r_tp);
                    end else if (r_reparse) begin
                        n_tp = f_pos_dec(r_tp);
                    end
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tlim   <= TOKEN_LIMIT_RST;
            r_tp     <= '0;
            r_istart <= '0;
            r_nfe    <= '0;
            r_op_v   <= 1'b0;
            r_tt     <= '0;
            r_mode   <= M_ROOT;
            r_esc    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tlim   <= n_tlim;
            r_tp     <= n_tp;
            r_istart <= n_istart;
            r_nfe    <= n_nfe;
            r_op_v   <= n_op_v;
            r_tt     <= n_tt;
            r_mode   <= n_mode;
            r_esc    <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_char    <= n_char;
        r_index   <= n_index;
        r_op      <= n_op;
        r_status  <= n_status;
        r_reparse <= n_reparse;
        r_feed    <= n_feed;
        r_to_root <= n_to_root;
        r_kind    <= n_kind;
        r_ptr     <= n_ptr;
        r_paddr   <= n_paddr;
        r_ety     <= n_ety;
        r_est     <= n_est;
        r_een     <= n_een;
        r_ech     <= n_ech;
    end

    // Results come straight from registers during the single done cycle.
    assign o_done           = (r_state == S_DONE);
    assign o_status         = r_status;
    assign o_parse_mode     = r_mode;
    assign o_tokens_found   = r_tt;
    assign o_entry_type     = r_ety;
    assign o_entry_start    = r_est;
    assign o_entry_end      = r_een;
    assign o_entry_children = r_ech;

    `JST_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    `JST_ASSERT_HOLDS(a_parent_alloc, i_clk, i_rst_n, r_op_v, NW'(r_op) < r_nfe)
    `JST_ASSERT_HOLDS(a_part_finish, i_clk, i_rst_n, o_done && o_status == ST_PART, r_cmd == CMD_FINISH)
    `JST_ASSERT_HOLDS(a_alloc_bound, i_clk, i_rst_n, 1'b1, LW'(r_nfe) <= TOK_MAX)
endmodule

[tb/tb_json_stream_tokenizer_core.sv]
// Self-checking testbench for json_stream_tokenizer_core: directed rows, then random JSON text.
// Depends on jst_pkg and the tokenizer RTL; predicts every result and compares all fields.
module tb_json_stream_tokenizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import jst_pkg::*;

    localparam int TBL_SIZE    = 64;
    localparam int STALL_LIMIT = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [7:0]  i_char_code;
    logic [5:0]  i_token_index;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        o_done;
    logic [1:0]  o_status;
    logic [2:0]  o_parse_mode;
    logic [6:0]  o_tokens_found;
    logic [1:0]  o_entry_type;
    logic [16:0] o_entry_start;
    logic [16:0] o_entry_end;
    logic [6:0]  o_entry_children;

    json_stream_tokenizer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_char_code     (i_char_code),
        .i_token_index   (i_token_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_parse_mode    (o_parse_mode),
        .o_tokens_found  (o_tokens_found),
        .o_entry_type    (o_entry_type),
        .o_entry_start   (o_entry_start),
        .o_entry_end     (o_entry_end),
        .o_entry_children(o_entry_children)
    );

    // One result of the tokenizer, as the output ports present it.
    typedef struct {
        logic [1:0]  st;
        logic [2:0]  md;
        logic [6:0]  total;
        logic [1:0]  ty;
        logic [16:0] s;
        logic [16:0] e;
        logic [6:0]  kids;
    } tok_result_t;

    // A directed row. When has_st is set, the status is typed in and overrides the prediction.
    typedef struct {
        logic [1:0] cmd;
        logic [7:0] ch;
        logic [5:0] idx;
        bit         has_st;
        logic [1:0] st;
    } dir_row_t;

    tok_result_t pending_results[$];
    byte unsigned text_q[$];
    int err_count = 0;
    int items_sent = 0;
    int idle_pct = 0;

    // Shadow of the tokenizer state: token table, register and parser registers.
    logic [1:0] tab_type [TBL_SIZE];
    int         tab_start[TBL_SIZE];
    int         tab_end  [TBL_SIZE];
    int         tab_kids [TBL_SIZE];
    bit         tab_used [TBL_SIZE];
    int limit_reg;
    int text_pos;
    int free_idx;
    int parent_idx;
    int tok_total;
    logic [2:0] pmode;
    int item_pos;
    bit esc_pend;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int next_pos(int p);
        return (p + 1) & 16'hFFFF;
    endfunction

    function automatic int prev_pos(int p);
        return (p == 0) ? 65535 : p - 1;
    endfunction

    function automatic void restart_parser();
        text_pos   = 0;
        free_idx   = 0;
        parent_idx = -1;
        tok_total  = 0;
        pmode      = M_ROOT;
        item_pos   = 0;
        esc_pend   = 1'b0;
    endfunction

    function automatic void bump_total();
        if (tok_total < 127) tok_total++;
    endfunction

    function automatic void bump_parent();
        if (parent_idx >= 0 && parent_idx < TBL_SIZE && tab_kids[parent_idx] < 127)
            tab_kids[parent_idx]++;
    endfunction

    function automatic bit entry_open(int i);
        return tab_start[i] != -1 && tab_end[i] == -1;
    endfunction

    // Claims the next table entry, or returns -1 when the usable table is full.
    function automatic int claim_entry();
        int lim;
        int i;
        lim = (limit_reg < TBL_SIZE) ? limit_reg : TBL_SIZE;
        if (free_idx >= lim) return -1;
        i = free_idx;
        free_idx++;
        tab_start[i] = -1;
        tab_end[i]   = -1;
        tab_kids[i]  = 0;
        tab_used[i]  = 1'b1;
        return i;
    endfunction

    // Character handling outside strings and primitives.
    function automatic logic [1:0] root_byte(logic [7:0] c);
        int i;
        bit found;
        logic [1:0] want;
        pmode = M_ROOT;
        case (c)
            "{", "[": begin
                bump_total();
                i = claim_entry();
                if (i < 0) return ST_NOMEM;
                bump_parent();
                tab_type[i]  = (c == "{") ? T_OBJECT : T_ARRAY;
                tab_start[i] = text_pos;
                parent_idx   = i;
            end
            "}", "]": begin
                want  = (c == "}") ? T_OBJECT : T_ARRAY;
                found = 1'b0;
                i = free_idx - 1;
                while (i >= 0 && !found) begin
                    if (entry_open(i)) begin
                        if (tab_type[i] != want) return ST_INVAL;
                        parent_idx = -1;
                        tab_end[i] = next_pos(text_pos);
                        found = 1'b1;
                    end else begin
                        i--;
                    end
                end
                if (!found) return ST_INVAL;
                // The closed entry is no longer open, so the walk for the new parent
                // continues from it downward.
                found = 1'b0;
                while (i >= 0 && !found) begin
                    if (entry_open(i)) begin
                        parent_idx = i;
                        found = 1'b1;
                    end else begin
                        i--;
                    end
                end
            end
            "\"": begin
                item_pos = text_pos;
                esc_pend = 1'b0;
                pmode    = M_STRING;
            end
            "\t", "\r", "\n", " ": ;
            ":": parent_idx = free_idx - 1;
            ",": begin
                if (parent_idx >= 0 && parent_idx < TBL_SIZE &&
                    tab_type[parent_idx] != T_ARRAY && tab_type[parent_idx] != T_OBJECT) begin
                    found = 1'b0;
                    for (i = free_idx - 1; i >= 0 && !found; i--) begin
                        if ((tab_type[i] == T_ARRAY || tab_type[i] == T_OBJECT) &&
                            entry_open(i)) begin
                            parent_idx = i;
                            found = 1'b1;
                        end
                    end
                end
            end
            default: begin
                item_pos = text_pos;
                pmode    = M_PRIM;
            end
        endcase
        return ST_OK;
    endfunction

    function automatic logic [1:0] string_byte(logic [7:0] c);
        int i;
        if (!esc_pend) begin
            if (c == "\\") begin
                esc_pend = 1'b1;
            end else if (c == "\"") begin
                i = claim_entry();
                if (i < 0) begin
                    text_pos = item_pos;
                    return ST_NOMEM;
                end
                tab_type[i]  = T_STRING;
                tab_start[i] = next_pos(item_pos);
                tab_end[i]   = text_pos;
                tab_kids[i]  = 0;
                bump_total();
                bump_parent();
                pmode = M_AFTER_STRING;
            end
            return ST_OK;
        end
        esc_pend = 1'b0;
        case (c)
            "\"", "/", "\\", "b", "f", "r", "n", "t": return ST_OK;
            default: begin
                text_pos = item_pos;
                return ST_INVAL;
            end
        endcase
    endfunction

    function automatic logic [1:0] prim_byte(logic [7:0] c);
        int i;
        logic [1:0] st;
        case (c)
            ":", "\t", "\r", "\n", " ", ",", "]", "}": begin
                i = claim_entry();
                if (i < 0) begin
                    text_pos = item_pos;
                    return ST_NOMEM;
                end
                tab_type[i]  = T_PRIM;
                tab_start[i] = item_pos;
                tab_end[i]   = text_pos;
                tab_kids[i]  = 0;
                bump_total();
                bump_parent();
                pmode = M_AFTER_PRIM;
                // The delimiter is parsed once more at root level; the primitive stays
                // even when that second pass fails.
                st = root_byte(c);
                if (st != ST_OK) text_pos = prev_pos(text_pos);
                return st;
            end
            default: begin
                if (c < 8'd32 || c >= 8'd127) begin
                    text_pos = item_pos;
                    return ST_INVAL;
                end
                return ST_OK;
            end
        endcase
    endfunction

    // Advances the shadow state by one command and returns the result it must produce.
    function automatic tok_result_t predict_tokenizer(logic [1:0] cmd, logic [7:0] c,
                                                      logic [5:0] idx);
        tok_result_t r;
        r = '{default: '0};
        r.st = ST_OK;
        case (cmd)
            CMD_FEED: begin
                if (pmode == M_STRING) r.st = string_byte(c);
                else if (pmode == M_PRIM) r.st = prim_byte(c);
                else r.st = root_byte(c);
                if (r.st == ST_OK) text_pos = next_pos(text_pos);
            end
            CMD_FINISH: begin
                for (int i = free_idx - 1; i >= 0; i--)
                    if (entry_open(i)) r.st = ST_PART;
            end
            CMD_RESTART: restart_parser();
            default: begin
                r.ty   = tab_type[idx];
                r.s    = tab_start[idx][16:0];
                r.e    = tab_end[idx][16:0];
                r.kids = tab_kids[idx][6:0];
            end
        endcase
        r.md    = pmode;
        r.total = tok_total[6:0];
        return r;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Result checker and watchdog. The watchdog counts cycles with neither a command
    // transfer nor a result, which bounds every hang of the block.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        tok_result_t w;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    $error("result with no command outstanding");
                    err_count++;
                end else begin
                    w = pending_results.pop_front();
                    compare_field("status", w.st, o_status);
                    compare_field("parse_mode", w.md, o_parse_mode);
                    compare_field("tokens_found", w.total, o_tokens_found);
                    compare_field("entry_type", w.ty, o_entry_type);
                    compare_field("entry_start", w.s, o_entry_start);
                    compare_field("entry_end", w.e, o_entry_end);
                    compare_field("entry_children", w.kids, o_entry_children);
                end
            end
            if (o_done || (start && !busy)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Presents one command at the falling edge and holds it until the transfer. Start is
    // left high afterwards so that back-to-back commands need no extra edge.
    task automatic send_cmd(logic [1:0] cmd, logic [7:0] c, logic [5:0] idx,
                            bit has_st = 1'b0, logic [1:0] st = ST_OK);
        tok_result_t r;
        bit taken;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        start         = 1'b1;
        i_command     = cmd;
        i_char_code   = c;
        i_token_index = idx;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        r = predict_tokenizer(cmd, c, idx);
        if (has_st) r.st = st;
        pending_results.push_back(r);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drops start and waits until every result is back and busy has cleared.
    task automatic drain();
        start = 1'b0;
        wait (pending_results.size() == 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [6:0] v);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        limit_reg = v;
    endtask

    // Reads one entry written since reset, else sends a finish; never-written entries are not touched.
    task automatic read_some_entry();
        int pick;
        pick = -1;
        for (int k = 0; k < 8 && pick < 0; k++) begin
            pick = $urandom_range(0, TBL_SIZE - 1);
            if (!tab_used[pick]) pick = -1;
        end
        if (pick < 0 && free_idx > 0) pick = $urandom_range(0, free_idx - 1);
        if (pick < 0) send_cmd(CMD_FINISH, $urandom, $urandom);
        else send_cmd(CMD_READ, $urandom, pick[5:0]);
    endtask

    function automatic void add_space();
        byte unsigned sp[4] = '{" ", "\t", "\r", "\n"};
        if ($urandom_range(0, 4) == 0) text_q.push_back(sp[$urandom_range(0, 3)]);
    endfunction

    function automatic void add_string();
        byte unsigned esc[8] = '{"\"", "/", "\\", "b", "f", "r", "n", "t"};
        byte unsigned b;
        text_q.push_back("\"");
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 9) == 0) begin
                text_q.push_back("\\");
                text_q.push_back(esc[$urandom_range(0, 7)]);
            end else begin
                // Bytes above 127 are legal inside strings.
                b = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 255)
                                                : $urandom_range(32, 126);
                if (b == "\"" || b == "\\") b = "x";
                text_q.push_back(b);
            end
        end
        text_q.push_back("\"");
    endfunction

    function automatic void add_value(int depth);
        string prim_chars = "0123456789-+.eEtrufalsn";
        int r;
        int n;
        r = $urandom_range(0, 9);
        if (depth < 3 && r < 2) begin
            text_q.push_back("{");
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++) begin
                if (k > 0) text_q.push_back(",");
                add_space();
                add_string();
                add_space();
                text_q.push_back(":");
                add_space();
                add_value(depth + 1);
                add_space();
            end
            text_q.push_back("}");
        end else if (depth < 3 && r < 4) begin
            text_q.push_back("[");
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++) begin
                if (k > 0) text_q.push_back(",");
                add_space();
                add_value(depth + 1);
                add_space();
            end
            text_q.push_back("]");
        end else if (r < 7) begin
            add_string();
        end else begin
            repeat ($urandom_range(1, 4))
                text_q.push_back(prim_chars[$urandom_range(0, prim_chars.len() - 1)]);
        end
    endfunction

    // One document: restart, the text, a finish check and a few entry reads. Some
    // documents get a byte replaced by noise or are cut short.
    task automatic run_document();
        text_q.delete();
        add_value(0);
        text_q.push_back(" ");
        if ($urandom_range(0, 5) == 0)
            text_q[$urandom_range(0, text_q.size() - 1)] = $urandom_range(0, 255);
        if ($urandom_range(0, 7) == 0)
            text_q = text_q[0:$urandom_range(0, text_q.size() - 1)];
        send_cmd(CMD_RESTART, $urandom, $urandom);
        foreach (text_q[k]) send_cmd(CMD_FEED, text_q[k], $urandom);
        send_cmd(CMD_FINISH, $urandom, $urandom);
        repeat ($urandom_range(1, 3)) read_some_entry();
    endtask

    // An array of 63 numbers fills all 64 entries, so the top table index gets read.
    task automatic run_full_table();
        send_cmd(CMD_RESTART, 8'h00, 6'h00);
        send_cmd(CMD_FEED, "[", 6'h00);
        for (int k = 0; k < 63; k++) begin
            send_cmd(CMD_FEED, "1", $urandom);
            send_cmd(CMD_FEED, (k == 62) ? "]" : ",", $urandom);
        end
        send_cmd(CMD_FINISH, 8'hFF, 6'h3F);
        send_cmd(CMD_READ, 8'h00, 6'd63);
        send_cmd(CMD_READ, 8'hFF, 6'd62);
    endtask

    // Openers keep counting past a full table, which drives the token count into saturation.
    task automatic run_count_saturation();
        send_cmd(CMD_RESTART, 8'h00, 6'h00);
        repeat (130) send_cmd(CMD_FEED, ($urandom_range(0, 1) == 0) ? "{" : "[", $urandom);
        send_cmd(CMD_FINISH, 8'h00, 6'h00);
    endtask

    dir_row_t dir_rows[] = '{
        '{CMD_FINISH,  8'h00, 6'h00, 1'b1, ST_OK},    // empty text is complete
        '{CMD_FEED,    "[",   6'h00, 1'b1, ST_OK},
        '{CMD_FINISH,  8'hFF, 6'h3F, 1'b1, ST_PART},  // open array
        '{CMD_FEED,    "\"",  6'h00, 1'b1, ST_OK},
        '{CMD_FEED,    "\\",  6'h00, 1'b1, ST_OK},
        '{CMD_FEED,    "q",   6'h00, 1'b1, ST_INVAL}, // bad escape
        '{CMD_FEED,    "\"",  6'h00, 1'b0, ST_OK},    // escape flag was cleared
        '{CMD_FEED,    ",",   6'h00, 1'b0, ST_OK},
        '{CMD_FEED,    "t",   6'h00, 1'b1, ST_OK},
        '{CMD_FEED,    8'h01, 6'h00, 1'b1, ST_INVAL}, // control byte in a primitive
        '{CMD_FEED,    8'hFF, 6'h00, 1'b1, ST_INVAL},
        '{CMD_FEED,    "}",   6'h00, 1'b1, ST_INVAL}, // primitive ends, brace mismatch
        '{CMD_FEED,    "]",   6'h00, 1'b1, ST_OK},
        '{CMD_FEED,    "]",   6'h00, 1'b1, ST_INVAL}, // nothing left open
        '{CMD_FINISH,  8'h00, 6'h00, 1'b1, ST_OK},
        '{CMD_READ,    8'h00, 6'h00, 1'b0, ST_OK},
        '{CMD_READ,    8'hFF, 6'h02, 1'b0, ST_OK},
        '{CMD_RESTART, 8'h00, 6'h00, 1'b1, ST_OK},
        '{CMD_FEED,    "{",   6'h00, 1'b1, ST_OK},
        '{CMD_FEED,    "\"",  6'h00, 1'b1, ST_OK},
        '{CMD_FEED,    "k",   6'h00, 1'b1, ST_OK},
        '{CMD_FEED,    "\"",  6'h00, 1'b1, ST_OK},
        '{CMD_FEED,    ":",   6'h00, 1'b1, ST_OK},
        '{CMD_FEED,    "7",   6'h00, 1'b1, ST_OK},
        '{CMD_FEED,    "}",   6'h00, 1'b1, ST_OK}
    };

    int phase_limits[7] = '{64, 0, 1, 5, 127, 20, 64};
    int phase_idle[3]   = '{0, 82, 9};

    initial begin
        start         = 1'b0;
        i_command     = CMD_FEED;
        i_char_code   = 8'h00;
        i_token_index = 6'h00;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 7'h00;
        i_rst_n       = 1'b0;
        foreach (tab_type[k]) begin
            tab_type[k]  = T_PRIM;
            tab_start[k] = 0;
            tab_end[k]   = 0;
            tab_kids[k]  = 0;
            tab_used[k]  = 1'b0;
        end
        limit_reg = TOKEN_LIMIT_RST;
        restart_parser();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k])
            send_cmd(dir_rows[k].cmd, dir_rows[k].ch, dir_rows[k].idx,
                     dir_rows[k].has_st, dir_rows[k].st);

        // Random phases: each sets a new table limit and a new idling pattern.
        foreach (phase_limits[p]) begin
            write_limit((p == 5) ? $urandom_range(2, 63) : phase_limits[p]);
            idle_pct = phase_idle[p % 3];
            if (limit_reg >= TBL_SIZE) run_full_table();
            if (p == 3) run_count_saturation();
            while (items_sent < 25 + 150 * (p + 1)) begin
                if ($urandom_range(0, 19) == 0) begin
                    // Stray commands between documents.
                    case ($urandom_range(0, 2))
                        0: send_cmd(CMD_FINISH, $urandom, $urandom);
                        1: read_some_entry();
                        default: send_cmd(CMD_FEED, $urandom, $urandom);
                    endcase
                end else begin
                    run_document();
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
